[rtl/rise_pkg.sv]
package rise_pkg;

  // Default bin depth
  localparam int unsigned BinSizeDefault = 64;

  // Field widths
  localparam int unsigned DistW   = 31;
  localparam int unsigned ShaderW = 32;
  localparam int unsigned HashW   = 64;
  localparam int unsigned TexW    = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned PosW    = 6;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned KeyW    = ShaderW + HashW + TexW + DistW;

  // Sort mode codes
  localparam logic [ModeW-1:0] ModeNone       = 3'd0;
  localparam logic [ModeW-1:0] ModeBackFront  = 3'd1;
  localparam logic [ModeW-1:0] ModeFrontBack  = 3'd2;
  localparam logic [ModeW-1:0] ModeFrontTrans = 3'd3;
  localparam logic [ModeW-1:0] ModeByState    = 3'd4;

  typedef logic [KeyW-1:0] key_t;

  // One bin slot: sort key plus the handle it carries
  typedef struct packed {
    logic               valid;
    key_t               key;
    logic [HandleW-1:0] handle;
  } entry_t;

  // Chain-wide control, the same for every cell
  typedef struct packed {
    logic insert;  // place the broadcast entry this cycle
    logic shift;   // move every slot one step toward the head
  } ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  // Fold the mode into one unsigned key: a strictly smaller key goes first.
  // Modes without ordering give every item the same key, so arrival order holds.
  function automatic key_t make_key(
    input logic [ModeW-1:0]   mode,
    input logic [DistW-1:0]   dist_sq,
    input logic               transp,
    input logic [ShaderW-1:0] shader,
    input logic [HashW-1:0]   hash,
    input logic [TexW-1:0]    tex
  );
    key_t k;
    k = '0;
    case (mode)
      ModeBackFront:  k = {{(KeyW-DistW){1'b0}}, ~dist_sq};
      ModeFrontBack:  k = {{(KeyW-DistW){1'b0}}, dist_sq};
      ModeFrontTrans: k = {{(KeyW-DistW-1){1'b0}}, transp, dist_sq};
      ModeByState:    k = {shader, hash, tex, dist_sq};
      default:        k = '0;
    endcase
    return k;
  endfunction

endpackage

[rtl/rise_cell.sv]
module rise_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rise_pkg::ctrl_t ctrl_i,
  input  rise_pkg::entry_t new_i,    // broadcast incoming entry
  input  rise_pkg::entry_t prev_i,   // neighbor toward the head
  input  logic            prev_ins_i,
  input  rise_pkg::entry_t next_i,   // neighbor toward the tail
  output rise_pkg::entry_t entry_o,
  output logic            ins_o
);

  logic               valid_q, valid_d;
  rise_pkg::key_t     key_q, key_d;
  logic [rise_pkg::HandleW-1:0] handle_q, handle_d;

  // New entry lands here or above: empty slot, or new key strictly smaller
  assign ins_o = !valid_q || (new_i.key < key_q);

  // Keep, take the new entry, or take a neighbor's
  always_comb begin
    valid_d  = valid_q;
    key_d    = key_q;
    handle_d = handle_q;
    if (ctrl_i.shift) begin
      valid_d  = next_i.valid;
      key_d    = next_i.key;
      handle_d = next_i.handle;
    end else if (ctrl_i.insert && ins_o) begin
      if (prev_ins_i) begin
        valid_d  = prev_i.valid;
        key_d    = prev_i.key;
        handle_d = prev_i.handle;
      end else begin
        valid_d  = 1'b1;
        key_d    = new_i.key;
        handle_d = new_i.handle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, handle: handle_q};

endmodule

[rtl/render_item_sort_engine_unit.sv]
// Render item sorter built as a systolic insertion chain of BIN_SIZE cells.
// Each accepted item is placed in its sorted slot in the cycle it is taken,
// so items load at one per cycle. The item with last_item set closes the bin:
// from the next cycle the chain shifts toward its head and emits one handle
// per cycle while out_ready_i stays high, and no input is taken until the
// final result (last_out_o) has been accepted. Ties keep arrival order. Items
// arriving at a full bin are dropped and every result of that bin reports
// overflowed_o. sort_mode must be written only while the block is idle;
// codes 5 to 7 give arrival order.
module render_item_sort_engine_unit #(
  parameter int unsigned BIN_SIZE = rise_pkg::BinSizeDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [rise_pkg::ModeW-1:0]      cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rise_pkg::DistW-1:0]      distance_sq_i,
  input  logic                            transparent_i,
  input  logic [rise_pkg::ShaderW-1:0]    shader_key_i,
  input  logic [rise_pkg::HashW-1:0]      state_hash_i,
  input  logic [rise_pkg::TexW-1:0]       texture_key_i,
  input  logic [rise_pkg::HandleW-1:0]    item_handle_i,
  input  logic                            last_item_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rise_pkg::HandleW-1:0]    out_handle_o,
  output logic [rise_pkg::PosW-1:0]       position_o,
  output logic                            overflowed_o,
  output logic                            last_out_o
);

  localparam int unsigned CntW = $clog2(BIN_SIZE + 1);

  rise_pkg::state_e              state_q, state_d;
  logic [rise_pkg::ModeW-1:0]    mode_q;
  logic [CntW-1:0]               count_q, count_d;
  logic [rise_pkg::PosW-1:0]     pos_q, pos_d;
  logic                          ovf_q, ovf_d;

  logic                          in_acc, out_acc, has_room;
  rise_pkg::ctrl_t               ctrl;
  rise_pkg::entry_t              new_entry;
  rise_pkg::entry_t              cells [BIN_SIZE];
  logic                          ins [BIN_SIZE];

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;
  assign has_room = count_q < CntW'(BIN_SIZE);

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rise_pkg::ModeNone;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Broadcast entry for the chain
  assign new_entry = '{
    valid:  1'b1,
    key:    rise_pkg::make_key(mode_q, distance_sq_i, transparent_i,
                               shader_key_i, state_hash_i, texture_key_i),
    handle: item_handle_i
  };

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rise_pkg::ST_FILL:  if (in_acc && last_item_i) state_d = rise_pkg::ST_DRAIN;
      rise_pkg::ST_DRAIN: if (out_acc && last_out_o) state_d = rise_pkg::ST_FILL;
      default:            state_d = rise_pkg::ST_FILL;
    endcase
  end

  // Handshake and chain control
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl        = '0;
    case (state_q)
      rise_pkg::ST_FILL: begin
        in_ready_o  = 1'b1;
        ctrl.insert = in_valid_i && has_room;
      end
      rise_pkg::ST_DRAIN: begin
        out_valid_o = 1'b1;
        ctrl.shift  = out_ready_i;
      end
      default: ;
    endcase
  end

  // Fill count, output rank and overflow flag
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    if (in_acc) begin
      if (has_room) begin
        count_d = count_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (out_acc) begin
      if (last_out_o) begin
        count_d = '0;
        pos_d   = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = count_q - CntW'(1);
        pos_d   = pos_q + rise_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rise_pkg::ST_FILL;
      count_q <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
    end
  end

  // Insertion chain: slot 0 is the head
  for (genvar i = 0; i < BIN_SIZE; i++) begin : g_cell
    rise_pkg::entry_t prev_e, next_e;
    logic             prev_ins;
    if (i == 0) begin : g_head
      assign prev_e   = '0;
      assign prev_ins = 1'b0;
    end else begin : g_mid
      assign prev_e   = cells[i-1];
      assign prev_ins = ins[i-1];
    end
    if (i == BIN_SIZE - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = cells[i+1];
    end
    rise_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_i      (new_entry),
      .prev_i     (prev_e),
      .prev_ins_i (prev_ins),
      .next_i     (next_e),
      .entry_o    (cells[i]),
      .ins_o      (ins[i])
    );
  end

  // The result handle comes straight from the head slot
  assign out_handle_o = cells[0].handle;
  assign position_o   = pos_q;
  assign overflowed_o = ovf_q;
  assign last_out_o   = count_q == CntW'(1);

`ifndef SYNTHESIS
  // Drain shows a result only from a filled head slot
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cells[0].valid)
    else $error("result offered from empty head slot");

  // Closing a bin starts the drain in the next cycle
  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_item_i) |=> (out_valid_o && !in_ready_o))
    else $error("bin close did not start drain");

  // Final result returns the chain to an empty, ready bin
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_out_o) |=> (in_ready_o && !cells[0].valid && count_q == '0))
    else $error("chain not empty after final result");

  // Never more stored items than slots
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(BIN_SIZE))
    else $error("fill count beyond capacity");
`endif

endmodule
